[design/ray_cylinder_nearest_hit_unit_assert.svh]
// Assertion macros used by the top-level design file.
`ifndef RAY_CYLINDER_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_CYLINDER_NEAREST_HIT_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge of aclk outside reset.
`define RCNH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCNH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rcnh_pkg.sv]
package rcnh_pkg;

    localparam int POS_W   = 24;
    localparam int R_W     = 23;
    localparam int DIR_W   = 18;
    localparam int AL_W    = 21;
    localparam int A_W     = 24;
    localparam int BE_W    = 27;
    localparam int B_W     = 34;
    localparam int C_W     = 38;
    localparam int D_W     = 62;
    localparam int S_W     = 31;
    localparam int SREM_W  = 34;
    localparam int DQ_W    = 23;
    localparam int DREM_W  = 25;
    localparam int NORM_W  = 17;
    localparam int CNT_W   = 7;

    localparam int SQRT_CELLS = S_W;
    localparam int DIV_CELLS  = DQ_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic CFG_OBSTACLE_COUNT = 1'b0;
    localparam logic CFG_MAX_RANGE      = 1'b1;

    localparam logic [NORM_W-1:0] NORM_NONE = 17'h10000;

    typedef struct packed {
        logic                     vld;
        logic                     ok;
        logic [D_W-1:0]           v;
        logic [SREM_W-1:0]        rem;
        logic [S_W-1:0]           root;
        logic signed [B_W-1:0]    b;
    } sq_t;

    typedef struct packed {
        logic                vld;
        logic                ok;
        logic [DQ_W-1:0]     lo;
        logic [DREM_W-1:0]   rem;
        logic [DQ_W-1:0]     q;
    } dv_t;

endpackage

[design/ray_cylinder_nearest_hit_unit.sv]
// A load writes its table slot on acceptance and the unit stays idle. A query first forms the
// ray cross product (S_PROD, S_ALPHA, S_SQ, S_SUM); unless its squared length a or n is zero,
// each of the n scanned cylinders then issues a table read into a 61-stage chain (6 product
// stages, 31 square-root cells, 1 check, 23 divider cells), the chain drains, a serial
// normalization runs and the output register is loaded. One item is worked on at a time.
// Synchronous reset (aresetn low) resets control and config registers, not data or the table.
module ray_cylinder_nearest_hit_unit #(
    parameter int MAX_CYLINDERS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, obs_x, obs_y, obs_z, obs_radius, dir_x, dir_y, dir_z, axis_x, axis_y, axis_z
    input  logic [215:0] s_tdata,
    // kind
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // nearest_norm, nearest_dist
    output logic [39:0]  m_tdata,
    // hit
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [22:0]  cfg_data
);
    localparam int AW    = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
    localparam int NW    = $clog2(MAX_CYLINDERS + 1);
    localparam int POS_W = rcnh_pkg::POS_W;
    localparam int ENT_W = 3 * rcnh_pkg::POS_W + rcnh_pkg::R_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_ALPHA, S_SQ, S_SUM, S_SCAN, S_DRAIN, S_NINIT, S_NORM, S_OUT
    } state_t;

    state_t state_reg;
    logic [rcnh_pkg::CNT_W-1:0] obstacle_count_reg;
    logic [22:0] max_range_reg;
    logic signed [rcnh_pkg::DIR_W-1:0] dx_reg, dy_reg, dz_reg, ax_reg, ay_reg, az_reg;
    logic signed [35:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [rcnh_pkg::AL_W-1:0] alx_reg, aly_reg, alz_reg;
    logic [41:0] sqx_reg, sqy_reg, sqz_reg;
    logic [rcnh_pkg::A_W-1:0] a_reg;
    logic [NW-1:0] cnt_reg, pend_reg;
    logic rd_vld_reg;
    logic [22:0] rmin_reg;
    logic hit_reg;
    logic [23:0] nrem_reg;
    logic [16:0] nbits_reg, nq_reg;
    logic [4:0] ncnt_reg;
    logic m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [0:0] m_tuser_reg;
    rcnh_pkg::dv_t pst_reg;

    logic in_acc, wr_en, issue, exit_vld;
    logic [10:0] n_full;
    logic [NW-1:0] n;
    logic [43:0] a_sum;
    logic [rcnh_pkg::A_W-1:0] a_next;
    logic [ENT_W-1:0] wr_data, rd_data;
    logic [24:0] nt;
    logic signed [34:0] num;
    logic [rcnh_pkg::NORM_W-1:0] norm_out;
    rcnh_pkg::sq_t sq [rcnh_pkg::SQRT_CELLS+1];
    rcnh_pkg::dv_t dv [rcnh_pkg::DIV_CELLS+1];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_acc  = s_tvalid && s_tready;
    assign wr_en   = in_acc && (s_tuser[0] == rcnh_pkg::KIND_LOAD)
                     && (11'(s_tdata[5:0]) < 11'(MAX_CYLINDERS));
    assign wr_data = s_tdata[100:6];
    assign issue   = (state_reg == S_SCAN);

    assign n_full = (11'(obstacle_count_reg) > 11'(MAX_CYLINDERS)) ?
                    11'(MAX_CYLINDERS) : 11'(obstacle_count_reg);
    assign n      = NW'(n_full);
    assign a_sum  = 44'(sqx_reg) + 44'(sqy_reg) + 44'(sqz_reg);
    assign a_next = rcnh_pkg::A_W'(a_sum >> 16);
    assign nt     = {nrem_reg, nbits_reg[16]};
    assign norm_out = (max_range_reg == '0) ? rcnh_pkg::NORM_NONE : nq_reg;

    rcnh_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CYLINDERS)) u_table (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_tdata[5:0])),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    rcnh_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vld_in  (rd_vld_reg),
        .pos_x   ($signed(rd_data[POS_W-1:0])),
        .pos_y   ($signed(rd_data[2*POS_W-1:POS_W])),
        .pos_z   ($signed(rd_data[3*POS_W-1:2*POS_W])),
        .radius  (rd_data[ENT_W-1:3*POS_W]),
        .axis_x  (ax_reg),
        .axis_y  (ay_reg),
        .axis_z  (az_reg),
        .alpha_x (alx_reg),
        .alpha_y (aly_reg),
        .alpha_z (alz_reg),
        .a_in    (a_reg),
        .sq_out  (sq[0])
    );

    for (genvar k = 0; k < rcnh_pkg::SQRT_CELLS; k++) begin : g_sqrt
        rcnh_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .d_in    (sq[k]),
            .d_out   (sq[k+1])
        );
    end

    assign num = 35'(sq[rcnh_pkg::SQRT_CELLS].b)
                 - $signed({4'd0, sq[rcnh_pkg::SQRT_CELLS].root});

    always_ff @(posedge aclk) begin
        pst_reg.ok  <= sq[rcnh_pkg::SQRT_CELLS].ok && (num > 0)
                       && (num < $signed({4'd0, a_reg, 7'd0}));
        pst_reg.rem <= rcnh_pkg::DREM_W'(num >>> 7);
        pst_reg.lo  <= {num[6:0], 16'd0};
        pst_reg.q   <= '0;
        if (!aresetn) begin
            pst_reg.vld <= 1'b0;
        end else begin
            pst_reg.vld <= sq[rcnh_pkg::SQRT_CELLS].vld;
        end
    end

    assign dv[0] = pst_reg;

    for (genvar k = 0; k < rcnh_pkg::DIV_CELLS; k++) begin : g_div
        rcnh_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .a_in    (a_reg),
            .d_in    (dv[k]),
            .d_out   (dv[k+1])
        );
    end

    assign exit_vld = dv[rcnh_pkg::DIV_CELLS].vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            obstacle_count_reg <= '0;
            max_range_reg      <= 23'd655360;
            cnt_reg            <= '0;
            pend_reg           <= '0;
            rd_vld_reg         <= 1'b0;
            hit_reg            <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            ncnt_reg           <= '0;
        end else begin
            rd_vld_reg <= issue;
            pend_reg   <= pend_reg + NW'(issue) - NW'(exit_vld);

            if (cfg_wr_en) begin
                unique case (cfg_index[0])
                    rcnh_pkg::CFG_OBSTACLE_COUNT: obstacle_count_reg <= cfg_data[6:0];
                    rcnh_pkg::CFG_MAX_RANGE:      max_range_reg      <= cfg_data;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (exit_vld && dv[rcnh_pkg::DIV_CELLS].ok
                && (dv[rcnh_pkg::DIV_CELLS].q != '0)
                && (dv[rcnh_pkg::DIV_CELLS].q < rmin_reg)) begin
                rmin_reg <= dv[rcnh_pkg::DIV_CELLS].q;
                hit_reg  <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && (s_tuser[0] == rcnh_pkg::KIND_QUERY)) begin
                        dx_reg   <= $signed(s_tdata[118:101]);
                        dy_reg   <= $signed(s_tdata[136:119]);
                        dz_reg   <= $signed(s_tdata[154:137]);
                        ax_reg   <= $signed(s_tdata[172:155]);
                        ay_reg   <= $signed(s_tdata[190:173]);
                        az_reg   <= $signed(s_tdata[208:191]);
                        rmin_reg <= max_range_reg;
                        hit_reg  <= 1'b0;
                        state_reg <= S_PROD;
                    end
                end
                S_PROD: begin
                    p0_reg <= 36'(dy_reg) * 36'(az_reg);
                    p1_reg <= 36'(dz_reg) * 36'(ay_reg);
                    p2_reg <= 36'(dz_reg) * 36'(ax_reg);
                    p3_reg <= 36'(dx_reg) * 36'(az_reg);
                    p4_reg <= 36'(dx_reg) * 36'(ay_reg);
                    p5_reg <= 36'(dy_reg) * 36'(ax_reg);
                    state_reg <= S_ALPHA;
                end
                S_ALPHA: begin
                    alx_reg <= rcnh_pkg::AL_W'((37'(p0_reg) - 37'(p1_reg)) >>> 16);
                    aly_reg <= rcnh_pkg::AL_W'((37'(p2_reg) - 37'(p3_reg)) >>> 16);
                    alz_reg <= rcnh_pkg::AL_W'((37'(p4_reg) - 37'(p5_reg)) >>> 16);
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    sqx_reg <= 42'(42'(alx_reg) * 42'(alx_reg));
                    sqy_reg <= 42'(42'(aly_reg) * 42'(aly_reg));
                    sqz_reg <= 42'(42'(alz_reg) * 42'(alz_reg));
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    a_reg   <= a_next;
                    cnt_reg <= '0;
                    if ((a_next == '0) || (n == '0)) begin
                        state_reg <= S_NINIT;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if ((cnt_reg + 1'b1) == n) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (pend_reg == '0) begin
                        state_reg <= S_NINIT;
                    end
                end
                S_NINIT: begin
                    nrem_reg  <= {2'b00, rmin_reg[22:1]};
                    nbits_reg <= {rmin_reg[0], 16'd0};
                    nq_reg    <= '0;
                    ncnt_reg  <= '0;
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    nbits_reg <= nbits_reg << 1;
                    if (nt >= 25'(max_range_reg)) begin
                        nrem_reg <= 24'(nt - 25'(max_range_reg));
                        nq_reg   <= {nq_reg[15:0], 1'b1};
                    end else begin
                        nrem_reg <= 24'(nt);
                        nq_reg   <= {nq_reg[15:0], 1'b0};
                    end
                    ncnt_reg <= ncnt_reg + 1'b1;
                    if (ncnt_reg == 5'(rcnh_pkg::NORM_W - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {rmin_reg, norm_out};
                        m_tuser_reg  <= hit_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "ray_cylinder_nearest_hit_unit_assert.svh"

    `RCNH_ASSERT_IMP(a_idle_empty, s_tready, pend_reg == '0, "input ready with work in flight")
    `RCNH_ASSERT_IMP(a_exit_pending, exit_vld, pend_reg != '0, "chain output without issue")
    `RCNH_ASSERT_IMP(a_hit_below_range, (state_reg != S_IDLE) && hit_reg,
        rmin_reg < max_range_reg, "hit distance not below range")
    `RCNH_ASSERT_IMP(a_hit_norm, m_tvalid && m_tuser[0],
        m_tdata[16:0] != rcnh_pkg::NORM_NONE, "hit reported with empty norm")
    `RCNH_ASSERT_NXT(a_scan_start, (state_reg == S_SUM) && (a_next != '0) && (n != '0),
        issue, "scan did not start")

endmodule

[design/rcnh_ram.sv]
module rcnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

[design/rcnh_front.sv]
module rcnh_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 vld_in,
    input  logic signed [rcnh_pkg::POS_W-1:0]    pos_x,
    input  logic signed [rcnh_pkg::POS_W-1:0]    pos_y,
    input  logic signed [rcnh_pkg::POS_W-1:0]    pos_z,
    input  logic [rcnh_pkg::R_W-1:0]             radius,
    input  logic signed [rcnh_pkg::DIR_W-1:0]    axis_x,
    input  logic signed [rcnh_pkg::DIR_W-1:0]    axis_y,
    input  logic signed [rcnh_pkg::DIR_W-1:0]    axis_z,
    input  logic signed [rcnh_pkg::AL_W-1:0]     alpha_x,
    input  logic signed [rcnh_pkg::AL_W-1:0]     alpha_y,
    input  logic signed [rcnh_pkg::AL_W-1:0]     alpha_z,
    input  logic [rcnh_pkg::A_W-1:0]             a_in,
    output rcnh_pkg::sq_t                        sq_out
);
    logic signed [41:0] pyaz_reg, pzay_reg, pzax_reg, pxaz_reg, pxay_reg, pyax_reg;
    logic [22:0] r1_reg;
    logic signed [rcnh_pkg::BE_W-1:0] bx_reg, by_reg, bz_reg;
    logic [45:0] rr2_reg, rr3_reg;
    logic signed [47:0] abx_reg, aby_reg, abz_reg;
    logic signed [53:0] bbx_reg, bby_reg, bbz_reg;
    logic signed [rcnh_pkg::B_W-1:0] b4_reg, b5_reg;
    logic signed [rcnh_pkg::C_W-1:0] c4_reg;
    logic signed [67:0] bb5_reg;
    logic [41:0] acl5_reg;
    logic signed [44:0] ach5_reg;
    logic [5:1] v_reg;
    logic signed [42:0] dbx, dby, dbz;
    logic signed [49:0] ab_sum;
    logic signed [55:0] bb_sum;
    logic signed [19:0] c_hi;
    logic signed [67:0] d6;
    rcnh_pkg::sq_t sq_next;

    always_comb begin
        dbx = 43'(pyaz_reg) - 43'(pzay_reg);
        dby = 43'(pzax_reg) - 43'(pxaz_reg);
        dbz = 43'(pxay_reg) - 43'(pyax_reg);
        ab_sum = 50'(abx_reg) + 50'(aby_reg) + 50'(abz_reg);
        bb_sum = 56'(bbx_reg) + 56'(bby_reg) + 56'(bbz_reg) - $signed({10'd0, rr3_reg});
        c_hi = 20'(c4_reg >>> 18);
        d6 = bb5_reg - ((68'(ach5_reg) <<< 18) + $signed({26'd0, acl5_reg}));
        sq_next.vld  = v_reg[5];
        sq_next.ok   = (d6 >= 0);
        sq_next.v    = d6[rcnh_pkg::D_W-1:0];
        sq_next.rem  = '0;
        sq_next.root = '0;
        sq_next.b    = b5_reg;
    end

    always_ff @(posedge aclk) begin
        pyaz_reg <= 42'(pos_y) * 42'(axis_z);
        pzay_reg <= 42'(pos_z) * 42'(axis_y);
        pzax_reg <= 42'(pos_z) * 42'(axis_x);
        pxaz_reg <= 42'(pos_x) * 42'(axis_z);
        pxay_reg <= 42'(pos_x) * 42'(axis_y);
        pyax_reg <= 42'(pos_y) * 42'(axis_x);
        r1_reg   <= radius;

        bx_reg  <= rcnh_pkg::BE_W'(dbx >>> 16);
        by_reg  <= rcnh_pkg::BE_W'(dby >>> 16);
        bz_reg  <= rcnh_pkg::BE_W'(dbz >>> 16);
        rr2_reg <= 46'(r1_reg) * 46'(r1_reg);

        abx_reg <= 48'(alpha_x) * 48'(bx_reg);
        aby_reg <= 48'(alpha_y) * 48'(by_reg);
        abz_reg <= 48'(alpha_z) * 48'(bz_reg);
        bbx_reg <= 54'(bx_reg) * 54'(bx_reg);
        bby_reg <= 54'(by_reg) * 54'(by_reg);
        bbz_reg <= 54'(bz_reg) * 54'(bz_reg);
        rr3_reg <= rr2_reg;

        b4_reg <= rcnh_pkg::B_W'(ab_sum >>> 16);
        c4_reg <= rcnh_pkg::C_W'(bb_sum >>> 16);

        bb5_reg  <= 68'(b4_reg) * 68'(b4_reg);
        acl5_reg <= 42'(a_in) * 42'(c4_reg[17:0]);
        ach5_reg <= $signed({21'd0, a_in}) * 45'(c_hi);
        b5_reg   <= b4_reg;

        sq_out <= sq_next;

        if (!aresetn) begin
            v_reg      <= '0;
            sq_out.vld <= 1'b0;
        end else begin
            v_reg <= {v_reg[4:1], vld_in};
        end
    end
endmodule

[design/rcnh_sqrt_cell.sv]
module rcnh_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  rcnh_pkg::sq_t  d_in,
    output rcnh_pkg::sq_t  d_out
);
    logic [rcnh_pkg::SREM_W+1:0] t;
    logic [rcnh_pkg::SREM_W+1:0] trial;
    rcnh_pkg::sq_t d_next;

    always_comb begin
        t     = {d_in.rem, d_in.v[rcnh_pkg::D_W-1 -: 2]};
        trial = (rcnh_pkg::SREM_W+2)'({d_in.root, 2'b01});
        d_next   = d_in;
        d_next.v = d_in.v << 2;
        if (t >= trial) begin
            d_next.rem  = rcnh_pkg::SREM_W'(t - trial);
            d_next.root = {d_in.root[rcnh_pkg::S_W-2:0], 1'b1};
        end else begin
            d_next.rem  = rcnh_pkg::SREM_W'(t);
            d_next.root = {d_in.root[rcnh_pkg::S_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        d_out <= d_next;
        if (!aresetn) begin
            d_out.vld <= 1'b0;
        end
    end
endmodule

[design/rcnh_div_cell.sv]
module rcnh_div_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rcnh_pkg::A_W-1:0]     a_in,
    input  rcnh_pkg::dv_t                d_in,
    output rcnh_pkg::dv_t                d_out
);
    logic [rcnh_pkg::DREM_W:0] t;
    rcnh_pkg::dv_t d_next;

    always_comb begin
        t = {d_in.rem, d_in.lo[rcnh_pkg::DQ_W-1]};
        d_next    = d_in;
        d_next.lo = d_in.lo << 1;
        if (t >= (rcnh_pkg::DREM_W+1)'(a_in)) begin
            d_next.rem = rcnh_pkg::DREM_W'(t - (rcnh_pkg::DREM_W+1)'(a_in));
            d_next.q   = {d_in.q[rcnh_pkg::DQ_W-2:0], 1'b1};
        end else begin
            d_next.rem = rcnh_pkg::DREM_W'(t);
            d_next.q   = {d_in.q[rcnh_pkg::DQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        d_out <= d_next;
        if (!aresetn) begin
            d_out.vld <= 1'b0;
        end
    end
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 200;
    localparam longint ONE_M = 65536;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en;
    logic [0:0]   cfg_index;
    logic [22:0]  cfg_data;

    ray_cylinder_nearest_hit_unit dut (.*);

    typedef struct {
        logic [rcnh_pkg::NORM_W-1:0] norm;
        logic [22:0]                 range_dist;
        logic                        hit;
    } hit_result_t;

    class hit_scoreboard;
        logic signed [rcnh_pkg::POS_W-1:0] tab_x[64];
        logic signed [rcnh_pkg::POS_W-1:0] tab_y[64];
        logic signed [rcnh_pkg::POS_W-1:0] tab_z[64];
        logic [rcnh_pkg::R_W-1:0]          tab_r[64];
        logic [rcnh_pkg::CNT_W-1:0]        scan_count;
        logic [22:0]                       range_q16;
        hit_result_t                       pending[$];
        int                                failures;
        int                                queries;
        int                                loads;
        int                                hits;
        int                                checked;

        function new();
            scan_count = '0;
            range_q16 = 23'd655360;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function automatic void set_reg(logic [0:0] idx, logic [22:0] val);
            if (idx == rcnh_pkg::CFG_OBSTACLE_COUNT) scan_count = val[rcnh_pkg::CNT_W-1:0];
            else range_q16 = val;
        endfunction

        function automatic void note_input(logic [0:0] kind, logic [215:0] d);
            longint dx, dy, dz, ax, ay, az, alx, aly, alz, a;
            longint px, py, pz, r, bx, by, bz, b, c, disc, s, num, root, rmin;
            int n;
            hit_result_t res;
            if (kind == rcnh_pkg::KIND_LOAD) begin
                tab_x[d[5:0]] = d[29:6];
                tab_y[d[5:0]] = d[53:30];
                tab_z[d[5:0]] = d[77:54];
                tab_r[d[5:0]] = d[100:78];
                loads++;
                return;
            end
            dx = longint'($signed(d[118:101]));
            dy = longint'($signed(d[136:119]));
            dz = longint'($signed(d[154:137]));
            ax = longint'($signed(d[172:155]));
            ay = longint'($signed(d[190:173]));
            az = longint'($signed(d[208:191]));
            alx = (dy * az - dz * ay) >>> 16;
            aly = (dz * ax - dx * az) >>> 16;
            alz = (dx * ay - dy * ax) >>> 16;
            a = (alx * alx + aly * aly + alz * alz) >>> 16;
            n = (scan_count > 64) ? 64 : int'(scan_count);
            rmin = longint'(range_q16);
            res.hit = 1'b0;
            for (int i = 0; i < n && a != 0; i++) begin
                px = longint'(tab_x[i]);
                py = longint'(tab_y[i]);
                pz = longint'(tab_z[i]);
                r = longint'(tab_r[i]);
                bx = (py * az - pz * ay) >>> 16;
                by = (pz * ax - px * az) >>> 16;
                bz = (px * ay - py * ax) >>> 16;
                b = (alx * bx + aly * by + alz * bz) >>> 16;
                c = (bx * bx + by * by + bz * bz - r * r) >>> 16;
                disc = b * b - a * c;
                if (disc < 0) continue;
                s = longint'(int_sqrt(64'(disc)));
                num = b - s;
                if (num <= 0) continue;
                root = (num * 65536) / a;
                if (root <= 0) continue;
                if (root < rmin) begin
                    rmin = root;
                    res.hit = 1'b1;
                end
            end
            if (range_q16 == 0) res.norm = rcnh_pkg::NORM_NONE;
            else res.norm = 17'((rmin << 16) / longint'(range_q16));
            res.range_dist = rmin[22:0];
            pending.insert(pending.size(), res);
            queries++;
            if (res.hit) hits++;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
            failures++;
        endtask

        task check_result(logic [39:0] d, logic [0:0] u);
            hit_result_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result transaction", longint'(d), 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (d[16:0] !== want.norm) report_mismatch("nearest_norm", d[16:0], want.norm);
            if (d[39:17] !== want.range_dist)
                report_mismatch("nearest_dist", d[39:17], want.range_dist);
            if (u[0] !== want.hit) report_mismatch("hit", u[0], want.hit);
        endtask
    endclass

    hit_scoreboard sb;
    int cycles;
    int burst_left;
    int stall_mode;
    int stall_left;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_index = '0;
        cfg_data = '0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: switches among always ready, random stalls and long stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [215:0] pack_item(logic [5:0] slot, logic [23:0] x, logic [23:0] y,
            logic [23:0] z, logic [22:0] r, logic [17:0] dx, logic [17:0] dy,
            logic [17:0] dz, logic [17:0] ax, logic [17:0] ay, logic [17:0] az);
        return {7'd0, az, ay, ax, dz, dy, dx, r, z, y, x, slot};
    endfunction

    task send_item(logic [0:0] kind, logic [215:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, d);
    endtask

    task wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_reg(logic [0:0] idx, logic [22:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task load_random(logic [5:0] slot);
        if ($urandom_range(0, 9) == 0)
            send_item(rcnh_pkg::KIND_LOAD, pack_item(slot, 24'($urandom), 24'($urandom),
                24'($urandom), 23'($urandom), '0, '0, '0, '0, '0, '0));
        else
            send_item(rcnh_pkg::KIND_LOAD, pack_item(slot,
                24'($signed($urandom_range(0, 1048576)) - 524288),
                24'($signed($urandom_range(0, 1048576)) - 524288),
                24'($signed($urandom_range(0, 1048576)) - 524288),
                23'($urandom_range(0, 2 * ONE_M)), 18'($urandom), 18'($urandom),
                18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom)));
    endtask

    function automatic logic [17:0] unit_comp();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task query_random();
        logic [17:0] ax, ay, az;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_item(rcnh_pkg::KIND_QUERY, pack_item(6'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom), 23'($urandom), 18'($urandom), 18'($urandom),
                18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom)));
        end else begin
            ax = '0;
            ay = '0;
            az = '0;
            case (pick % 4)
                0: ax = 18'sd65536;
                1: ay = -18'sd65536;
                2: az = 18'sd65536;
                default: begin
                    ax = unit_comp();
                    ay = unit_comp();
                    az = unit_comp();
                end
            endcase
            send_item(rcnh_pkg::KIND_QUERY, pack_item(6'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom), 23'($urandom),
                unit_comp(), unit_comp(), unit_comp(), ax, ay, az));
        end
    endtask

    initial begin
        int counts[6];
        int ranges[6];
        sb = new();
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: the obstacle count is still zero, so the first query scans no entries.
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, 18'sd65536, '0, '0,
            '0, '0, 18'sd65536));
        send_item(rcnh_pkg::KIND_LOAD, pack_item(6'd0, '0, 24'sd196608, '0, 23'd65536,
            '0, '0, '0, '0, '0, '0));
        send_item(rcnh_pkg::KIND_LOAD, pack_item(6'd1, 24'sd8388607, 24'h800000, 24'sd8388607,
            23'd8388607, '0, '0, '0, '0, '0, '0));
        send_item(rcnh_pkg::KIND_LOAD, pack_item(6'd2, 24'h800000, '0, '0, 23'd0,
            '0, '0, '0, '0, '0, '0));
        send_item(rcnh_pkg::KIND_LOAD, pack_item(6'd3, 24'sd131072, 24'sd131072, '0, 23'd32768,
            '0, '0, '0, '0, '0, '0));
        wait_idle();
        write_reg(rcnh_pkg::CFG_OBSTACLE_COUNT, 23'd4);
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, '0, 18'sd65536, '0,
            '0, '0, 18'sd65536));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, '0, -18'sd65536, '0,
            '0, '0, 18'sd65536));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, '0, '0, 18'sd65536,
            '0, '0, 18'sd65536));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, 18'sd46341, 18'sd46341,
            '0, '0, '0, 18'sd65536));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, 18'h20000, 18'h20000,
            18'sd131071, 18'sd131071, 18'h20000, 18'sd131071));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, -18'sd65536, '0, '0,
            '0, 18'sd65536, '0));
        wait_idle();
        write_reg(rcnh_pkg::CFG_MAX_RANGE, '0);
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, '0, 18'sd65536, '0,
            '0, '0, 18'sd65536));
        wait_idle();
        write_reg(rcnh_pkg::CFG_MAX_RANGE, 23'd8388607);
        write_reg(rcnh_pkg::CFG_OBSTACLE_COUNT, 23'd127);
        for (int i = 4; i < 64; i++) load_random(6'(i));
        send_item(rcnh_pkg::KIND_QUERY, pack_item('0, '0, '0, '0, '0, '0, 18'sd65536, '0,
            '0, '0, 18'sd65536));

        counts = '{64, 127, 1, 0, 23, 40};
        ranges = '{655360, 8388607, 1, 655360, 0, 1310720};
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_reg(rcnh_pkg::CFG_OBSTACLE_COUNT, 23'(counts[ph]));
            write_reg(rcnh_pkg::CFG_MAX_RANGE,
                23'((ph == 5) ? $urandom_range(1, 8388607) : ranges[ph]));
            for (int k = 0; k < 240; k++) begin
                if ($urandom_range(0, 9) < 3) load_random(6'($urandom));
                else query_random();
            end
        end

        wait_idle();
        $display("Covered %0d load and %0d query transactions; %0d results checked, %0d hits.",
            sb.loads, sb.queries, sb.checked, sb.hits);
        $display("Scan counts 0 to 127 and ranges 0 to full scale were exercised.");
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/rcnh_pkg.sv
design/rcnh_ram.sv
design/rcnh_front.sv
design/rcnh_sqrt_cell.sv
design/rcnh_div_cell.sv
design/ray_cylinder_nearest_hit_unit.sv
dv/testbench.sv
